// File: hdl/spq_pkg.sv
// Shared types and constants of the stable priority queue.
`default_nettype none
package spq_pkg;

    localparam int OCC_BITS = 5;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/stable_priority_queue_unit.sv
// Top level of the stable priority queue: cell chain, fill count and result register.
//
// Channel   Dir  Beat contents
// s_        in   tuser: cmd; tdata: item_value, item_rank
// m_        out  tuser: out_valid, status; tdata: out_value, out_rank, occupancy
//
// Every accepted input beat yields exactly one result beat in the following cycle.
// A beat is taken every cycle unless stalled; each slot decides locally from its own
// rank and its neighbor whether it keeps, loads the new entry or shifts.
// The result register stalls intake only while its beat waits on m_tready.
// Reset (aresetn low at a clock edge) empties the queue and the result register.
`default_nettype none
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 16,
    parameter int RANK_BITS  = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // tdata from bit 0: item_value, item_rank, zero fill.
    input  wire logic [((VALUE_BITS+RANK_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: cmd.
    input  wire logic             s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // tdata from bit 0: out_value, out_rank, occupancy, zero fill.
    output logic [((VALUE_BITS+RANK_BITS+OCC_BITS+7)/8)*8-1:0] m_tdata,
    // tuser from bit 0: out_valid, status.
    output logic [2:0]            m_tuser
);

    localparam int OUT_DW = ((VALUE_BITS + RANK_BITS + OCC_BITS + 7) / 8) * 8;
    localparam int CW     = $clog2(CAPACITY + 1);

    logic [CW-1:0]          count_reg, count_next;
    logic                   m_valid_reg;
    logic [OUT_DW-1:0]      m_data_reg, m_data_next;
    logic [2:0]             m_user_reg, m_user_next;

    logic                   accept, is_enq, is_deq, full, empty;
    spq_ctrl_t              ctrl;
    logic [VALUE_BITS-1:0]  in_value;
    logic [RANK_BITS-1:0]   in_rank;

    logic                   cell_keep  [CAPACITY];
    logic [VALUE_BITS-1:0]  cell_value [CAPACITY];
    logic [RANK_BITS-1:0]   cell_rank  [CAPACITY];

    logic                   res_valid;
    logic [VALUE_BITS-1:0]  res_value;
    logic [RANK_BITS-1:0]   res_rank;
    status_t                res_status;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_rank  = s_tdata[VALUE_BITS +: RANK_BITS];
    assign is_enq   = (cmd_t'(s_tuser) == CMD_ENQ);
    assign is_deq   = (cmd_t'(s_tuser) == CMD_DEQ);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign ctrl.enq = accept && is_enq && !full;
    assign ctrl.deq = accept && is_deq && !empty;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  prev_keep;
        logic [VALUE_BITS-1:0] prev_value, next_value;
        logic [RANK_BITS-1:0]  prev_rank, next_rank;

        if (i == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_value = in_value;
            assign prev_rank  = in_rank;
        end else begin : g_body
            assign prev_keep  = cell_keep[i-1];
            assign prev_value = cell_value[i-1];
            assign prev_rank  = cell_rank[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[i];
            assign next_rank  = cell_rank[i];
        end else begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_rank  = cell_rank[i+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .RANK_BITS  (RANK_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (count_reg > CW'(i)),
            .new_value  (in_value),
            .new_rank   (in_rank),
            .prev_keep  (prev_keep),
            .prev_value (prev_value),
            .prev_rank  (prev_rank),
            .next_value (next_value),
            .next_rank  (next_rank),
            .keep       (cell_keep[i]),
            .value      (cell_value[i]),
            .rank       (cell_rank[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        res_valid  = 1'b0;
        res_value  = '0;
        res_rank   = '0;
        res_status = ST_OK;
        if (ctrl.enq) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.deq) begin
            count_next = count_reg - CW'(1);
            res_valid  = 1'b1;
            res_value  = cell_value[0];
            res_rank   = cell_rank[0];
        end else if (accept && is_enq) begin
            res_status = ST_FULL;
        end else if (accept) begin
            res_status = ST_EMPTY;
        end
        m_data_next = OUT_DW'({OCC_BITS'(count_next), res_rank, res_value});
        m_user_next = {res_status, res_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.enq |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted enqueue did not grow the queue");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CW'(2) |-> cell_rank[0] <= cell_rank[1])
        else $error("head entries out of rank order");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg[0] |-> status_t'(m_user_reg[2:1]) == ST_OK)
        else $error("returned entry with error status");

endmodule
`default_nettype wire

// File: hdl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and shifts, loads or keeps it.
`default_nettype none
module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int RANK_BITS  = 4
) (
    input  wire logic                  aclk,
    input  wire spq_ctrl_t             ctrl,
    input  wire logic                  occupied,
    input  wire logic [VALUE_BITS-1:0] new_value,
    input  wire logic [RANK_BITS-1:0]  new_rank,
    input  wire logic                  prev_keep,
    input  wire logic [VALUE_BITS-1:0] prev_value,
    input  wire logic [RANK_BITS-1:0]  prev_rank,
    input  wire logic [VALUE_BITS-1:0] next_value,
    input  wire logic [RANK_BITS-1:0]  next_rank,
    output logic                       keep,
    output logic [VALUE_BITS-1:0]      value,
    output logic [RANK_BITS-1:0]       rank
);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [RANK_BITS-1:0]  rank_reg, rank_next;

    // An occupied slot whose rank is not above the new one stays where it is.
    assign keep  = occupied && (rank_reg <= new_rank);
    assign value = value_reg;
    assign rank  = rank_reg;

    always_comb begin
        value_next = value_reg;
        rank_next  = rank_reg;
        if (ctrl.enq) begin
            if (!keep) begin
                if (prev_keep) begin
                    value_next = new_value;
                    rank_next  = new_rank;
                end else begin
                    value_next = prev_value;
                    rank_next  = prev_rank;
                end
            end
        end else if (ctrl.deq) begin
            value_next = next_value;
            rank_next  = next_rank;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the stable priority queue with a built-in predictor.
`default_nettype none
module testbench;
    import spq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 16;
    localparam int RANK_BITS  = 4;
    localparam int S_DATA_W   = ((VALUE_BITS + RANK_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((VALUE_BITS + RANK_BITS + OCC_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                  present;
        logic [VALUE_BITS-1:0] value;
        logic [RANK_BITS-1:0]  rank;
        status_t               status;
        logic [OCC_BITS-1:0]   occupancy;
    } queue_reply_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = CMD_ENQ;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [2:0]          m_tuser;

    logic [VALUE_BITS-1:0] shadow_value [CAPACITY];
    logic [RANK_BITS-1:0]  shadow_rank  [CAPACITY];
    int                    shadow_fill = 0;
    queue_reply_t          expected_replies [$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;

    stable_priority_queue_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .RANK_BITS  (RANK_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic queue_reply_t predict_reply(input cmd_t cmd,
                                                   input logic [VALUE_BITS-1:0] value,
                                                   input logic [RANK_BITS-1:0] rank);
        queue_reply_t reply;
        int pos;
        reply = '{present: 1'b0, value: '0, rank: '0, status: ST_OK, occupancy: '0};
        if (cmd == CMD_ENQ) begin
            if (shadow_fill >= CAPACITY) begin
                reply.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_fill && shadow_rank[pos] <= rank) pos++;
                for (int k = shadow_fill; k > pos; k--) begin
                    shadow_value[k] = shadow_value[k-1];
                    shadow_rank[k]  = shadow_rank[k-1];
                end
                shadow_value[pos] = value;
                shadow_rank[pos]  = rank;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            reply.status = ST_EMPTY;
        end else begin
            reply.present = 1'b1;
            reply.value   = shadow_value[0];
            reply.rank    = shadow_rank[0];
            for (int k = 1; k < shadow_fill; k++) begin
                shadow_value[k-1] = shadow_value[k];
                shadow_rank[k-1]  = shadow_rank[k];
            end
            shadow_fill--;
        end
        reply.occupancy = shadow_fill[OCC_BITS-1:0];
        return reply;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : reply_monitor
        queue_reply_t seen;
        queue_reply_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(predict_reply(cmd_t'(s_tuser),
                    s_tdata[VALUE_BITS-1:0], s_tdata[VALUE_BITS+RANK_BITS-1:VALUE_BITS]));
            end
            if (m_tvalid && m_tready) begin
                seen.present   = m_tuser[0];
                seen.status    = status_t'(m_tuser[2:1]);
                seen.value     = m_tdata[VALUE_BITS-1:0];
                seen.rank      = m_tdata[VALUE_BITS+RANK_BITS-1:VALUE_BITS];
                seen.occupancy = m_tdata[VALUE_BITS+RANK_BITS+OCC_BITS-1:VALUE_BITS+RANK_BITS];
                if (expected_replies.size() == 0) begin
                    note_failure($sformatf("unexpected result beat valid=%0b value=%h rank=%0d status=%0d occ=%0d",
                        seen.present, seen.value, seen.rank, seen.status, seen.occupancy));
                end else begin
                    want = expected_replies.pop_front();
                    if (seen !== want) begin
                        note_failure($sformatf({"mismatch: expected valid=%0b value=%h rank=%0d ",
                            "status=%0d occ=%0d, got valid=%0b value=%h rank=%0d status=%0d occ=%0d"},
                            want.present, want.value, want.rank, want.status, want.occupancy,
                            seen.present, seen.value, seen.rank, seen.status, seen.occupancy));
                    end
                end
            end
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [VALUE_BITS-1:0] value,
                             input logic [RANK_BITS-1:0] rank);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_DATA_W'({rank, value});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic run_traffic(input int n_items, input bit hold_mid);
        int   enq_pct;
        cmd_t cmd;
        logic [RANK_BITS-1:0] rank;
        enq_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            if (hold_mid && i == n_items / 2) wait_for_replies();
            cmd  = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            rank = $urandom_range(1) ? RANK_BITS'($urandom_range(3)) : RANK_BITS'($urandom);
            send_item(cmd, VALUE_BITS'($urandom), rank);
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_item(CMD_DEQ, 16'hFFFF, 4'hF);
        send_item(CMD_ENQ, 16'h0000, 4'd15);
        send_item(CMD_ENQ, 16'hFFFF, 4'd0);
        send_item(CMD_ENQ, 16'h1234, 4'd7);
        send_item(CMD_ENQ, 16'h5555, 4'd7);
        send_item(CMD_ENQ, 16'hAAAA, 4'd7);
        send_item(CMD_ENQ, 16'h0001, 4'd15);
        send_item(CMD_ENQ, 16'h8000, 4'd0);
        for (int i = 0; i < 9; i++) begin
            send_item(CMD_ENQ, 16'h0F0F ^ VALUE_BITS'(i), RANK_BITS'(i));
        end
        send_item(CMD_ENQ, 16'hBEEF, 4'd0);
        repeat (3) send_item(CMD_DEQ, 16'h0000, 4'd0);
        send_item(CMD_ENQ, 16'h4321, 4'd0);
        repeat (2) send_item(CMD_DEQ, 16'hFFFF, 4'hF);
        wait_for_replies();
    endtask

    task automatic test_stable_order_no_idle();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        run_traffic(320, 1'b0);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 77;
        sink_stall_pct = 0;
        run_traffic(320, 1'b1);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 77;
        run_traffic(320, 1'b0);
    endtask

    task automatic test_both_sides_idle();
        send_idle_pct  = 30;
        sink_stall_pct = 30;
        run_traffic(320, 1'b1);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_stable_order_no_idle();
        test_sender_gaps();
        test_receiver_backpressure();
        test_both_sides_idle();
        wait_for_replies();
        repeat (4) @(posedge aclk);
        if (expected_replies.size() != 0) note_failure("expected results left over");
        if (fail_count == 0) begin
            $display("** stable_priority_queue_unit: PASSED **");
        end else begin
            $display("** stable_priority_queue_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #(20 * 200000);
        $display("** stable_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_unit.sv
tb/testbench.sv
